@@ rtl/slffr_pkg.sv @@
// shared constants and types of the sync / length / fletcher-16 frame receiver
`timescale 1ns / 1ps
package slffr_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
  localparam int BYTE_W = 8;
  localparam int LEN_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h7E;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 7'd64;

  // frame descriptor written by the front end
  typedef struct packed {
    logic             push;
    logic [LEN_W-1:0] len;
  } desc_wr_t;

  // head of the descriptor queue as the back end sees it
  typedef struct packed {
    logic             empty;
    logic [LEN_W-1:0] len;
  } desc_rd_t;

endpackage

@@ rtl/slffr_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module slffr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/slffr_front.sv @@
// front end: config registers, frame parser, fletcher-16 check, payload store writes
`timescale 1ns / 1ps
module slffr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [slffr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slffr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [slffr_pkg::BYTE_W-1:0]     rx_byte,
  input  logic                             store_busy,
  input  logic                             q_full,
  output slffr_pkg::desc_wr_t              desc_wr,
  output logic                             ram_we,
  output logic [slffr_pkg::ADDR_W-1:0]     ram_addr,
  output logic [slffr_pkg::BYTE_W-1:0]     ram_data
);
  import slffr_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CHECK1  = 5'b01000,
    PH_CHECK2  = 5'b10000
  } phase_t;

  phase_t             phase;
  logic [BYTE_W-1:0]  sync_value;
  logic [LEN_W-1:0]   max_payload;
  logic [LEN_W-1:0]   expected_length;
  logic [LEN_W-1:0]   byte_count;
  logic [LEN_W-1:0]   byte_count_next;
  logic [BYTE_W-1:0]  sum_a;
  logic [BYTE_W-1:0]  sum_a_next;
  logic [BYTE_W-1:0]  sum_b;
  logic [BYTE_W-1:0]  first_check;
  logic [BYTE_W-1:0]  limit;
  logic               accept;
  logic               check_ok;

  // payload waits while the store is still being drained; a frame's second check byte waits for queue room
  assign full = ((phase == PH_PAYLOAD) && store_busy) || ((phase == PH_CHECK2) && q_full);
  assign accept = push && !full;

  assign limit = (max_payload > LEN_W'(MAX_FRAME_BYTES)) ? BYTE_W'(MAX_FRAME_BYTES)
                                                        : BYTE_W'(max_payload);
  assign sum_a_next = sum_a + rx_byte;
  assign byte_count_next = byte_count + LEN_W'(1);
  assign check_ok = (first_check == sum_b) && (rx_byte == sum_a);

  assign desc_wr.push = accept && (phase == PH_CHECK2) && check_ok;
  assign desc_wr.len = expected_length;

  assign ram_we = accept && (phase == PH_PAYLOAD);
  assign ram_addr = byte_count[ADDR_W-1:0];
  assign ram_data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYNC_VALUE:  sync_value <= cfg_data;
        REG_MAX_PAYLOAD: max_payload <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      expected_length <= '0;
      byte_count <= '0;
      sum_a <= '0;
      sum_b <= '0;
      first_check <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == sync_value) begin
            phase <= PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (rx_byte <= limit) begin
            expected_length <= rx_byte[LEN_W-1:0];
            byte_count <= '0;
            sum_a <= '0;
            sum_b <= '0;
            phase <= (rx_byte == '0) ? PH_CHECK1 : PH_PAYLOAD;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          sum_a <= sum_a_next;
          sum_b <= sum_b + sum_a_next;
          byte_count <= byte_count_next;
          if (byte_count_next >= expected_length) begin
            phase <= PH_CHECK1;
          end
        end
        PH_CHECK1: begin
          first_check <= rx_byte;
          phase <= PH_CHECK2;
        end
        PH_CHECK2: begin
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    desc_wr.push |-> !q_full)
    else $error("descriptor written into a full queue");

  a_store_write_safe: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (!store_busy && (byte_count < expected_length)))
    else $error("payload store written while being drained or past frame end");
`endif

endmodule

@@ rtl/slffr_desc_q.sv @@
// two-entry queue of good-frame descriptors between front and back end
`timescale 1ns / 1ps
module slffr_desc_q (
  input  logic                clk,
  input  logic                rst,
  input  slffr_pkg::desc_wr_t desc_wr,
  output logic                q_full,
  input  logic                q_pop,
  output slffr_pkg::desc_rd_t desc_rd
);
  import slffr_pkg::*;

  logic [LEN_W-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign q_full = (count == 2'd2);
  assign desc_rd.empty = (count == 2'd0);
  assign desc_rd.len = entry[rd_ptr];
  assign do_push = desc_wr.push && !q_full;
  assign do_pop = q_pop && !desc_rd.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= desc_wr.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/slffr_back.sv @@
// back end: reads a good frame out of the payload store and presents one result at a time
`timescale 1ns / 1ps
module slffr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  slffr_pkg::desc_rd_t          desc_rd,
  output logic                         q_pop,
  output logic                         busy,
  output logic                         ram_re,
  output logic [slffr_pkg::ADDR_W-1:0] ram_addr,
  input  logic [slffr_pkg::BYTE_W-1:0] ram_rdata,
  output logic                         empty,
  input  logic                         pop,
  output logic [slffr_pkg::BYTE_W-1:0] payload_byte,
  output logic [slffr_pkg::LEN_W-1:0]  frame_length,
  output logic                         last,
  output logic                         empty_frame
);
  import slffr_pkg::*;

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_READ = 4'b0010,
    BK_LOAD = 4'b0100,
    BK_SHOW = 4'b1000
  } back_state_t;

  back_state_t       state;
  logic [ADDR_W-1:0] rd_idx;
  logic [LEN_W-1:0]  rd_idx_next;

  assign rd_idx_next = LEN_W'(rd_idx) + LEN_W'(1);
  assign q_pop = (state == BK_IDLE) && !desc_rd.empty;
  assign busy = (state != BK_IDLE);
  assign empty = (state != BK_SHOW);
  assign ram_re = (state == BK_READ);
  assign ram_addr = rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rd_idx <= '0;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (!desc_rd.empty) begin
            rd_idx <= '0;
            state <= (desc_rd.len == '0) ? BK_SHOW : BK_READ;
          end
        end
        BK_READ: state <= BK_LOAD;
        BK_LOAD: state <= BK_SHOW;
        BK_SHOW: begin
          if (pop) begin
            if (last) begin
              state <= BK_IDLE;
            end else begin
              rd_idx <= rd_idx_next[ADDR_W-1:0];
              state <= BK_READ;
            end
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_length <= desc_rd.len;
      payload_byte <= '0;
      empty_frame <= (desc_rd.len == '0);
      last <= (desc_rd.len == '0);
    end else if (state == BK_LOAD) begin
      payload_byte <= ram_rdata;
      last <= (rd_idx_next == frame_length);
    end
  end

`ifndef SYNTH
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SHOW && !pop) |=> (state == BK_SHOW) && $stable(payload_byte) && $stable(last))
    else $error("waiting result changed before it was taken");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SHOW && pop && last) |=> (state == BK_IDLE))
    else $error("frame continued after its last result");
`endif

endmodule

@@ rtl/sync_length_fletcher_frame_receiver.sv @@
// top level of the sync / length / fletcher-16 frame receiver
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  input   | push / full        | rx_byte
//  result  | pop / empty        | payload_byte, frame_length, last, empty_frame
//  config  | cfg_write          | cfg_index, cfg_data (0 sync_value, 1 max_payload)
//
// received bytes are taken one per cycle; payload bytes stall (full) while a previous
// good frame is still being read out of the 64-byte payload store.
// each payload result takes a queue pop or advance, a store read and a result load, and
// is held until pop takes it before the next is fetched; an empty frame shows in the cycle
// after its queue pop.
// any frame waits at its second check byte while the two-entry descriptor queue is full.
// synchronous active-high reset; no clearing pass, the store is only read where written.
`timescale 1ns / 1ps
module sync_length_fletcher_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [slffr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slffr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [slffr_pkg::BYTE_W-1:0]     rx_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [slffr_pkg::BYTE_W-1:0]     payload_byte,
  output logic [slffr_pkg::LEN_W-1:0]      frame_length,
  output logic                             last,
  output logic                             empty_frame
);
  import slffr_pkg::*;

  desc_wr_t          desc_wr;
  desc_rd_t          desc_rd;
  logic              q_full;
  logic              q_pop;
  logic              back_busy;
  logic              store_busy;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;

  assign store_busy = !desc_rd.empty || back_busy;

  slffr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .rx_byte    (rx_byte),
    .store_busy (store_busy),
    .q_full     (q_full),
    .desc_wr    (desc_wr),
    .ram_we     (ram_we),
    .ram_addr   (ram_wr_addr),
    .ram_data   (ram_wr_data)
  );

  slffr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  slffr_desc_q u_desc_q (
    .clk     (clk),
    .rst     (rst),
    .desc_wr (desc_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .desc_rd (desc_rd)
  );

  slffr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .desc_rd      (desc_rd),
    .q_pop        (q_pop),
    .busy         (back_busy),
    .ram_re       (ram_re),
    .ram_addr     (ram_rd_addr),
    .ram_rdata    (ram_rd_data),
    .empty        (empty),
    .pop          (pop),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .last         (last),
    .empty_frame  (empty_frame)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the sync / length / fletcher-16 frame receiver
`timescale 1ns / 1ps
module tb_top;
  import slffr_pkg::*;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct {
    byte_t            data;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             empty_frame;
  } delivery_t;

  typedef enum logic [2:0] {
    HUNT_SYNC,
    READ_LENGTH,
    READ_PAYLOAD,
    READ_CHECK_B,
    READ_CHECK_A
  } parse_phase_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 32;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  byte_t                 rx_byte = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  byte_t                 payload_byte;
  logic [LEN_W-1:0]      frame_length;
  logic                  last;
  logic                  empty_frame;

  // stimulus and expected deliveries
  byte_t     rx_stream[$];
  byte_t     frame_buf[$];
  delivery_t pending_deliveries[$];

  // register copies as the block should hold them
  byte_t            cfg_sync = SYNC_RESET;
  logic [LEN_W-1:0] cfg_max = MAX_PAYLOAD_RESET;

  // frame parser state mirrored by the testbench
  parse_phase_t     rx_phase;
  logic [LEN_W-1:0] want_len;
  logic [LEN_W-1:0] got_count;
  byte_t            fl_a;
  byte_t            fl_b;
  byte_t            check_b_byte;
  byte_t            frame_mem[MAX_FRAME_BYTES];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int bytes_taken = 0;
  int results_checked = 0;
  int frames_delivered = 0;
  int empty_frames = 0;
  int quiet_cycles = 0;

  sync_length_fletcher_frame_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .last         (last),
    .empty_frame  (empty_frame)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // advance the mirrored parser by one received byte
  task automatic parse_rx_byte(input byte_t b);
    int accept_lim;
    delivery_t d;
    accept_lim = (int'(cfg_max) > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(cfg_max);
    case (rx_phase)
      HUNT_SYNC: begin
        if (b == cfg_sync) rx_phase = READ_LENGTH;
      end
      READ_LENGTH: begin
        if (int'(b) <= accept_lim) begin
          want_len = b[LEN_W-1:0];
          got_count = '0;
          fl_a = '0;
          fl_b = '0;
          rx_phase = (want_len == 0) ? READ_CHECK_B : READ_PAYLOAD;
        end else begin
          rx_phase = HUNT_SYNC;
        end
      end
      READ_PAYLOAD: begin
        if (int'(got_count) < MAX_FRAME_BYTES) frame_mem[got_count] = b;
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
        got_count = got_count + 1'b1;
        if (got_count >= want_len) rx_phase = READ_CHECK_B;
      end
      READ_CHECK_B: begin
        check_b_byte = b;
        rx_phase = READ_CHECK_A;
      end
      default: begin
        if (check_b_byte == fl_b && b == fl_a) begin
          if (want_len == 0) begin
            d.data = '0;
            d.len = '0;
            d.last = 1'b1;
            d.empty_frame = 1'b1;
            pending_deliveries.push_back(d);
          end else begin
            for (int k = 0; k < int'(want_len) && k < MAX_FRAME_BYTES; k++) begin
              d.data = frame_mem[k];
              d.len = want_len;
              d.last = (k + 1 == int'(want_len));
              d.empty_frame = 1'b0;
              pending_deliveries.push_back(d);
            end
          end
        end
        rx_phase = HUNT_SYNC;
      end
    endcase
  endtask

  // sender: one byte held on rx_byte until it is taken
  always @(posedge clk) begin : sender
    logic push_next;
    if (rst) begin
      push <= 1'b0;
      rx_phase = HUNT_SYNC;
      want_len = '0;
      got_count = '0;
      fl_a = '0;
      fl_b = '0;
      check_b_byte = '0;
    end else begin
      push_next = push;
      if (push && !full) begin
        parse_rx_byte(rx_byte);
        bytes_taken++;
        push_next = 1'b0;
      end
      if (!push_next && rx_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        rx_byte <= rx_stream.pop_front();
        push_next = 1'b1;
      end
      push <= push_next;
    end
  end

  // receiver: random pop, every taken result checked against the oldest expectation
  always @(posedge clk) begin : receiver
    delivery_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_deliveries.size() == 0) begin
          report_mismatch($sformatf("unexpected result, payload_byte %h", payload_byte));
        end else begin
          want = pending_deliveries.pop_front();
          if (payload_byte !== want.data)
            report_mismatch($sformatf("payload_byte %h, want %h", payload_byte, want.data));
          if (frame_length !== want.len)
            report_mismatch($sformatf("frame_length %0d, want %0d", frame_length, want.len));
          if (last !== want.last)
            report_mismatch($sformatf("last %b, want %b", last, want.last));
          if (empty_frame !== want.empty_frame)
            report_mismatch($sformatf("empty_frame %b, want %b", empty_frame, want.empty_frame));
          results_checked++;
          if (want.last) frames_delivered++;
          if (want.empty_frame) empty_frames++;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_SYNC_VALUE) cfg_sync = value[BYTE_W-1:0];
    else cfg_max = value[LEN_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // every byte taken, every result back, then a margin for a trailing bad frame
  task automatic wait_drained;
    while (rx_stream.size() != 0 || push || pending_deliveries.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // sync, length, payload and the two check bytes; a bad frame gets one check byte spoilt
  task automatic build_frame(input int len, input bit good);
    byte_t a, b, v;
    a = '0;
    b = '0;
    frame_buf.delete();
    frame_buf.push_back(cfg_sync);
    frame_buf.push_back(byte_t'(len));
    for (int k = 0; k < len; k++) begin
      v = byte_t'($urandom_range(255));
      a = a + v;
      b = b + a;
      frame_buf.push_back(v);
    end
    if (!good) begin
      if ($urandom_range(1)) b = b ^ byte_t'($urandom_range(255, 1));
      else a = a ^ byte_t'($urandom_range(255, 1));
    end
    frame_buf.push_back(b);
    frame_buf.push_back(a);
  endtask

  task automatic queue_frame(input int len, input bit good);
    build_frame(len, good);
    foreach (frame_buf[i]) rx_stream.push_back(frame_buf[i]);
  endtask

  // mostly well-formed frames with short payloads, some noise and oversize lengths
  task automatic queue_traffic(input int n_bytes);
    int added, lim, r, len;
    added = 0;
    lim = (int'(cfg_max) > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(cfg_max);
    while (added < n_bytes) begin
      r = $urandom_range(99);
      if (r < 10) begin
        rx_stream.push_back(byte_t'($urandom_range(255)));
        added++;
      end else if (r < 18) begin
        rx_stream.push_back(cfg_sync);
        rx_stream.push_back(byte_t'($urandom_range(255, lim + 1)));
        added += 2;
      end else begin
        if (r >= 98) len = lim;
        else len = $urandom_range((lim < 8) ? lim : 8, 0);
        queue_frame(len, $urandom_range(99) < 80);
        added += frame_buf.size();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset registers, no idling
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    queue_frame(0, 1'b1);
    queue_frame(1, 1'b1);
    queue_frame(2, 1'b0);
    rx_stream.push_back(cfg_sync);
    rx_stream.push_back(8'd65);
    rx_stream.push_back(cfg_sync);
    rx_stream.push_back(8'hFF);
    queue_frame(3, 1'b1);
    wait_drained();

    // sync 0x00, limit register above the store size, sender idling
    write_register(REG_SYNC_VALUE, 8'h00);
    write_register(REG_MAX_PAYLOAD, 8'd127);
    sender_idle_pct = 58;
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'd100);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'd65);
    queue_frame(MAX_FRAME_BYTES, 1'b1);
    // open a frame, then change both registers before its tail arrives
    build_frame(5, 1'b1);
    for (int i = 0; i < 4; i++) rx_stream.push_back(frame_buf[i]);
    wait_drained();
    write_register(REG_SYNC_VALUE, 8'hFF);
    write_register(REG_MAX_PAYLOAD, 8'd0);
    for (int i = 4; i < frame_buf.size(); i++) rx_stream.push_back(frame_buf[i]);

    // only empty frames fit now, receiver stalling
    sender_idle_pct = 0;
    recv_stall_pct = 58;
    queue_traffic(8);
    wait_drained();

    write_register(REG_SYNC_VALUE, byte_t'($urandom_range(254, 1)));
    write_register(REG_MAX_PAYLOAD, CFG_DATA_W'($urandom_range(63, 1)));
    sender_idle_pct = 36;
    recv_stall_pct = 36;
    queue_traffic(8);
    wait_drained();

    write_register(REG_MAX_PAYLOAD, CFG_DATA_W'(MAX_PAYLOAD_RESET));
    write_register(REG_SYNC_VALUE, SYNC_RESET);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    queue_traffic(4);
    wait_drained();
    repeat (64) @(negedge clk);

    $display("summary: %0d bytes received, %0d results checked, %0d good frames (%0d empty)",
             bytes_taken, results_checked, frames_delivered, empty_frames);
    $display("summary: sync 0x7e/0x00/0xff/random, limits 64/127/0/random, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
